FILE: rtl/prb_pkg.sv
// shared constants, types and register codes of the planar rotate block
// no dependencies; imported by prb_cfg, prb_bank and the top level
package prb_pkg;

  localparam int MAX_LINES   = 512;
  localparam int MAX_COLUMNS = 512;

  // index widths into the plane; at least two bits so parity banking works
  localparam int LIDX_W = ($clog2(MAX_LINES) < 2) ? 2 : $clog2(MAX_LINES);
  localparam int CIDX_W = ($clog2(MAX_COLUMNS) < 2) ? 2 : $clog2(MAX_COLUMNS);
  localparam int BA_W   = (LIDX_W - 1) + (CIDX_W - 1);

  localparam int SZ_W   = 13;  // plane sizes up to 4096
  localparam int TRIG_W = 14;
  localparam int PW     = 26;  // config products and quotients
  localparam int DIV_W  = 25;  // dividend magnitude
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int STEP_W = 15;  // per row step, trunc(cos/a) and trunc(-sin/a)
  localparam int MW     = 25;  // per item products
  localparam int LW     = 28;  // q12 source position
  localparam int POS_W  = 20;  // integer source line / column

  localparam logic signed [LW-1:0] HALF_Q12 = LW'(1 << 11);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_SINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COSINE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL   = 3'd5;

  localparam logic signed [TRIG_W-1:0] SINE_RST   = 14'sd2048;
  localparam logic signed [TRIG_W-1:0] COSINE_RST = 14'sd3547;

  typedef struct packed {
    logic signed [LW-1:0]     kl;
    logic signed [LW-1:0]     kc;
    logic signed [STEP_W-1:0] dl;
    logic signed [STEP_W-1:0] dc;
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
    logic [SZ_W-1:0]          lines;
    logic [SZ_W-1:0]          cols;
    logic [SZ_W-1:0]          lc;
    logic [SZ_W-1:0]          cc;
    logic [2:0]               a;
    logic [7:0]               fill;
  } coef_t;

endpackage

FILE: rtl/prb_cfg.sv
// configuration registers and the sequencer that derives rotation coefficients
// uses prb_pkg; one shared restoring divider handles the four aspect divisions
module prb_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prb_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           busy,
  output prb_pkg::coef_t                 coef
);
  import prb_pkg::*;

  typedef enum logic [2:0] {ST_PREP, ST_MUL, ST_LOAD, ST_DIV, ST_FIN, ST_IDLE} state_t;

  state_t                   state_r;
  logic signed [TRIG_W-1:0] sine_r, cosine_r;
  logic [9:0]               line_count_r, column_count_r;
  logic [2:0]               row_aspect_r;
  logic [7:0]               fill_r;

  logic [SZ_W-1:0]          lines_r, cols_r, lc_r, cc_r;
  logic [2:0]               a_r;
  logic signed [PW-1:0]     p_cl_r, p_sl_r, p_sc_r, p_cc_r;
  logic [DIV_W-1:0]         dq_r;
  logic [2:0]               rem_r;
  logic                     neg_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [1:0]               idx_r;
  logic signed [PW-1:0]     q_r [4];
  logic signed [LW-1:0]     kl_r, kc_r;

  logic [SZ_W-1:0]            line_sz, col_sz, lines_nxt, cols_nxt;
  logic signed [TRIG_W+SZ_W:0] mul_cl, mul_sl, mul_sc, mul_cc;
  logic signed [PW-1:0]       num, num_abs, q_mag, q_val;
  logic [3:0]                 sh;
  logic                       ge;
  logic [2:0]                 rem_step;
  logic [DIV_W-1:0]           dq_step;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    line_sz   = {3'b000, line_count_r};
    col_sz    = {3'b000, column_count_r};
    lines_nxt = (line_count_r == 10'd0) ? SZ_W'(1) :
                (line_sz > SZ_W'(MAX_LINES)) ? SZ_W'(MAX_LINES) : line_sz;
    cols_nxt  = (column_count_r == 10'd0) ? SZ_W'(1) :
                (col_sz > SZ_W'(MAX_COLUMNS)) ? SZ_W'(MAX_COLUMNS) : col_sz;

    mul_cl = cosine_r * $signed({1'b0, lc_r});
    mul_sl = sine_r * $signed({1'b0, lc_r});
    mul_sc = sine_r * $signed({1'b0, cc_r});
    mul_cc = cosine_r * $signed({1'b0, cc_r});

    case (idx_r)
      2'd0:    num = p_cl_r;
      2'd1:    num = p_sl_r;
      2'd2:    num = {{(PW-TRIG_W){cosine_r[TRIG_W-1]}}, cosine_r};
      default: num = -{{(PW-TRIG_W){sine_r[TRIG_W-1]}}, sine_r};
    endcase
    num_abs = num[PW-1] ? -num : num;

    // one restoring step per cycle
    sh       = {rem_r, dq_r[DIV_W-1]};
    ge       = (sh >= {1'b0, a_r});
    rem_step = ge ? 3'(sh - {1'b0, a_r}) : sh[2:0];
    dq_step  = {dq_r[DIV_W-2:0], ge};
    q_mag    = $signed({{(PW-DIV_W){1'b0}}, dq_step});
    q_val    = neg_r ? -q_mag : q_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_PREP;
      sine_r         <= SINE_RST;
      cosine_r       <= COSINE_RST;
      line_count_r   <= 10'd512;
      column_count_r <= 10'd512;
      row_aspect_r   <= 3'd1;
      fill_r         <= 8'd0;
      idx_r          <= 2'd0;
      cnt_r          <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SINE:   sine_r         <= $signed(cfg_data[TRIG_W-1:0]);
        CFG_COSINE: cosine_r       <= $signed(cfg_data[TRIG_W-1:0]);
        CFG_LINES:  line_count_r   <= cfg_data[9:0];
        CFG_COLS:   column_count_r <= cfg_data[9:0];
        CFG_ASPECT: row_aspect_r   <= cfg_data[2:0];
        CFG_FILL:   fill_r         <= cfg_data[7:0];
        default:    ;
      endcase
      // any write restarts the coefficient derivation
      state_r <= ST_PREP;
    end else begin
      unique case (state_r)
        ST_PREP: begin
          lines_r <= lines_nxt;
          cols_r  <= cols_nxt;
          lc_r    <= lines_nxt >> 1;
          cc_r    <= cols_nxt >> 1;
          a_r     <= (row_aspect_r == 3'd0) ? 3'd1 : row_aspect_r;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          p_cl_r  <= -mul_cl[PW-1:0];
          p_sl_r  <= mul_sl[PW-1:0];
          p_sc_r  <= mul_sc[PW-1:0];
          p_cc_r  <= mul_cc[PW-1:0];
          idx_r   <= 2'd0;
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          dq_r    <= num_abs[DIV_W-1:0];
          neg_r   <= num[PW-1];
          rem_r   <= 3'd0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          dq_r  <= dq_step;
          rem_r <= rem_step;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_W - 1)) begin
            q_r[idx_r] <= q_val;
            idx_r      <= idx_r + 2'd1;
            state_r    <= (idx_r == 2'd3) ? ST_FIN : ST_LOAD;
          end
        end
        ST_FIN: begin
          kl_r    <= {{(LW-PW){q_r[0][PW-1]}}, q_r[0]}
                     - {{(LW-PW){p_sc_r[PW-1]}}, p_sc_r} + HALF_Q12;
          kc_r    <= {{(LW-PW){q_r[1][PW-1]}}, q_r[1]}
                     - {{(LW-PW){p_cc_r[PW-1]}}, p_cc_r} + HALF_Q12;
          state_r <= ST_IDLE;
        end
        ST_IDLE: state_r <= ST_IDLE;
        default: state_r <= ST_PREP;
      endcase
    end
  end

  always_comb begin
    coef.kl    = kl_r;
    coef.kc    = kc_r;
    coef.dl    = q_r[2][STEP_W-1:0];
    coef.dc    = q_r[3][STEP_W-1:0];
    coef.s     = sine_r;
    coef.c     = cosine_r;
    coef.lines = lines_r;
    coef.cols  = cols_r;
    coef.lc    = lc_r;
    coef.cc    = cc_r;
    coef.a     = a_r;
    coef.fill  = fill_r;
  end

endmodule

FILE: rtl/prb_bank.sv
// one parity bank of the plane store: one write and one registered read a cycle
// uses prb_pkg for the address width
module prb_bank (
  input  logic                     clk,
  input  logic                     we,
  input  logic [prb_pkg::BA_W-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [prb_pkg::BA_W-1:0] raddr,
  output logic [7:0]               rdata
);
  import prb_pkg::*;

  logic [7:0] mem_r [2**BA_W];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/planar_rotate_bilinear_top.sv
// planar rotation with bilinear blend: seven stage pipeline over a 2x2 banked store
// uses prb_pkg, prb_cfg and prb_bank
//
//  channel  direction  handshake          transaction
//  in_      to block   in_valid/in_stall  kind, row, column, pixel_in
//  out_     from block out_valid/out_stall pixel_out, row, column
//  cfg_     to block   cfg_valid/cfg_ready index, 14 bit data
//
// one transaction enters per cycle while in_stall is low; a compute result leaves from the stage 7 registers
// write transactions land in the store as they leave stage 4 and give no result
// after reset and after every cfg write the coefficient sequencer runs its prep, multiply,
// four divide passes on the shared divider and finish steps, holding in_stall high meanwhile
// rst_n is synchronous; a stalled stage holds, bubbles ahead of it are filled
module planar_rotate_bilinear_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [8:0]                     in_row,
  input  logic [8:0]                     in_column,
  input  logic [7:0]                     in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_pixel_out,
  output logic [8:0]                     out_row,
  output logic [8:0]                     out_column,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import prb_pkg::*;

  coef_t coef;
  logic  busy;

  prb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .coef      (coef)
  );

  // stage valid bits and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
  logic accept;

  assign rdy7     = !v7_r || !out_stall;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = busy || !rdy1;
  assign accept   = in_valid && !in_stall;

  // stage payloads
  logic                    kind1_r, kind2_r, kind3_r, kind4_r;
  logic [8:0]              row1_r, row2_r, row3_r, row4_r, row5_r, row6_r, row7_r;
  logic [8:0]              col1_r, col2_r, col3_r, col4_r, col5_r, col6_r, col7_r;
  logic [7:0]              pix1_r, pix2_r, pix3_r, pix4_r, pix7_r;
  logic signed [MW-1:0]    m_rl_r, m_cs_r, m_rc_r, m_cc_r;
  logic signed [LW-1:0]    l3_r, c3_r;
  logic signed [POS_W-1:0] lo4_r, co4_r;
  logic [7:0]              fl4_r, fc4_r, fl5_r, fc5_r, fl6_r;
  logic                    inr5_r, inr6_r, lo0_5_r, co0_5_r;
  logic [1:0]              rv5_r, cv5_r;
  logic [16:0]             t0_6_r, t1_6_r;

  // stage 1 -> 2: position products
  logic signed [MW-1:0] m_rl, m_cs, m_rc, m_cc;
  always_comb begin
    m_rl = $signed({1'b0, row1_r}) * coef.dl;
    m_cs = $signed({1'b0, col1_r}) * coef.s;
    m_rc = $signed({1'b0, row1_r}) * coef.dc;
    m_cc = $signed({1'b0, col1_r}) * coef.c;
  end

  // stage 2 -> 3: q12 source position
  logic signed [LW-1:0] l_sum, c_sum;
  always_comb begin
    l_sum = coef.kl + {{(LW-MW){m_rl_r[MW-1]}}, m_rl_r}
                    + {{(LW-MW){m_cs_r[MW-1]}}, m_cs_r};
    c_sum = coef.kc + {{(LW-MW){m_rc_r[MW-1]}}, m_rc_r}
                    + {{(LW-MW){m_cc_r[MW-1]}}, m_cc_r};
  end

  // stage 3 -> 4: integer line and column, floor shift, then aspect step on the line only
  logic signed [LW-13:0]   fq_l, fq_c;
  logic signed [POS_W-1:0] lo_mul, lo_nxt, co_nxt;
  always_comb begin
    fq_l   = l3_r[LW-1:12];
    fq_c   = c3_r[LW-1:12];
    lo_mul = fq_l * $signed({1'b0, coef.a});
    lo_nxt = lo_mul + $signed({{(POS_W-SZ_W){1'b0}}, coef.lc});
    co_nxt = {{(POS_W-LW+12){fq_c[LW-13]}}, fq_c}
             + $signed({{(POS_W-SZ_W){1'b0}}, coef.cc});
  end

  // stage 4 -> 5: neighbour checks, bank addresses and the store access
  logic signed [POS_W-1:0] lines_s, cols_s, lo_p1, co_p1;
  logic [1:0]              rv, cv;
  logic                    inr;
  logic [POS_W-1:0]        rsel, csel;
  logic [1:0]              bsel;
  logic [SZ_W-1:0]         wrow, wcol;
  logic                    wok;
  logic [1:0]              wbank;
  logic [BA_W-1:0]         waddr;
  logic [BA_W-1:0]         rd_addr [4];
  logic                    bank_we [4];
  logic [7:0]              rd_data [4];

  always_comb begin
    lines_s = $signed({{(POS_W-SZ_W){1'b0}}, coef.lines});
    cols_s  = $signed({{(POS_W-SZ_W){1'b0}}, coef.cols});
    lo_p1   = lo4_r + POS_W'(1);
    co_p1   = co4_r + POS_W'(1);
    rv[0]   = (lo4_r >= 0) && (lo4_r < lines_s);
    rv[1]   = (lo_p1 >= 0) && (lo_p1 < lines_s);
    cv[0]   = (co4_r >= 0) && (co4_r < cols_s);
    cv[1]   = (co_p1 >= 0) && (co_p1 < cols_s);
    inr     = (lo4_r >= -1) && (lo4_r < lines_s) && (co4_r >= -1) && (co4_r < cols_s);

    wrow  = {{(SZ_W-9){1'b0}}, row4_r};
    wcol  = {{(SZ_W-9){1'b0}}, col4_r};
    wok   = (wrow < SZ_W'(MAX_LINES)) && (wcol < SZ_W'(MAX_COLUMNS));
    wbank = {row4_r[0], col4_r[0]};
    waddr = {wrow[LIDX_W-1:1], wcol[CIDX_W-1:1]};

    for (int b = 0; b < 4; b++) begin
      bsel       = 2'(b);
      // bank of line parity p holds whichever of lo, lo+1 has that parity
      rsel       = (lo4_r[0] == bsel[1]) ? lo4_r : lo_p1;
      csel       = (co4_r[0] == bsel[0]) ? co4_r : co_p1;
      rd_addr[b] = {rsel[LIDX_W-1:1], csel[CIDX_W-1:1]};
      bank_we[b] = v4_r && !kind4_r && rdy5 && wok && (wbank == bsel);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    prb_bank u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (waddr),
      .wdata (pix4_r),
      .re    (rdy5),
      .raddr (rd_addr[g]),
      .rdata (rd_data[g])
    );
  end

  // stage 5 -> 6: neighbours with fill, then horizontal blend
  logic [7:0]  p00, p01, p10, p11;
  logic [8:0]  wc0, wc1, wl0, wl1;
  logic [16:0] t0, t1;
  logic [25:0] acc;
  always_comb begin
    p00 = (rv5_r[0] && cv5_r[0]) ? rd_data[{lo0_5_r, co0_5_r}]   : coef.fill;
    p01 = (rv5_r[0] && cv5_r[1]) ? rd_data[{lo0_5_r, !co0_5_r}]  : coef.fill;
    p10 = (rv5_r[1] && cv5_r[0]) ? rd_data[{!lo0_5_r, co0_5_r}]  : coef.fill;
    p11 = (rv5_r[1] && cv5_r[1]) ? rd_data[{!lo0_5_r, !co0_5_r}] : coef.fill;
    wc1 = {1'b0, fc5_r};
    wc0 = 9'd256 - wc1;
    t0  = 17'(p00 * wc0) + 17'(p01 * wc1);
    t1  = 17'(p10 * wc0) + 17'(p11 * wc1);
    // stage 6 -> 7: vertical blend
    wl1 = {1'b0, fl6_r};
    wl0 = 9'd256 - wl1;
    acc = 26'(t0_6_r * wl0) + 26'(t1_6_r * wl1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= accept;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r && kind4_r;  // write transactions end here
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      kind1_r <= in_kind;
      row1_r  <= in_row;
      col1_r  <= in_column;
      pix1_r  <= in_pixel_in;
    end
    if (rdy2) begin
      kind2_r <= kind1_r;
      row2_r  <= row1_r;
      col2_r  <= col1_r;
      pix2_r  <= pix1_r;
      m_rl_r  <= m_rl;
      m_cs_r  <= m_cs;
      m_rc_r  <= m_rc;
      m_cc_r  <= m_cc;
    end
    if (rdy3) begin
      kind3_r <= kind2_r;
      row3_r  <= row2_r;
      col3_r  <= col2_r;
      pix3_r  <= pix2_r;
      l3_r    <= l_sum;
      c3_r    <= c_sum;
    end
    if (rdy4) begin
      kind4_r <= kind3_r;
      row4_r  <= row3_r;
      col4_r  <= col3_r;
      pix4_r  <= pix3_r;
      lo4_r   <= lo_nxt;
      co4_r   <= co_nxt;
      fl4_r   <= l3_r[11:4];
      fc4_r   <= c3_r[11:4];
    end
    if (rdy5) begin
      row5_r  <= row4_r;
      col5_r  <= col4_r;
      inr5_r  <= inr;
      fl5_r   <= fl4_r;
      fc5_r   <= fc4_r;
      lo0_5_r <= lo4_r[0];
      co0_5_r <= co4_r[0];
      rv5_r   <= rv;
      cv5_r   <= cv;
    end
    if (rdy6) begin
      row6_r <= row5_r;
      col6_r <= col5_r;
      inr6_r <= inr5_r;
      fl6_r  <= fl5_r;
      t0_6_r <= t0;
      t1_6_r <= t1;
    end
    if (rdy7) begin
      row7_r <= row6_r;
      col7_r <= col6_r;
      pix7_r <= inr6_r ? acc[23:16] : coef.fill;
    end
  end

  assign out_valid     = v7_r;
  assign out_pixel_out = pix7_r;
  assign out_row       = row7_r;
  assign out_column    = col7_r;

  // no transaction slips in while coefficients are being rebuilt
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("transaction accepted while coefficients busy");

  // write transactions never reach the blend stages
  a_write_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !kind4_r && rdy5) |=> !v5_r)
    else $error("write transaction produced a result");

  // a held read stage keeps its store data in banks 0 and 3
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !rdy5) |=> (v5_r && $stable(rd_data[0]) && $stable(rd_data[3])))
    else $error("store read data lost under stall");

endmodule
